/* rtl/core/lms_pkg.sv */
// Shared constants, types and helpers for the longest monotone subsequence block.
`default_nettype none

package lms_pkg;

  localparam int ALPHABET = 26;
  localparam int MAX_LEN  = 1024;

  localparam int SYM_W   = 5;
  localparam int IDX_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IN_W    = ((SYM_W + 7) / 8) * 8;
  localparam int OUT_W   = ((LEN_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  // One table step as issued by the top level
  typedef struct packed {
    logic step;
    logic last;
    idx_t idx;
  } lms_req_t;

  // Clamp an out-of-alphabet symbol to the top letter
  function automatic idx_t sym_to_idx(input logic [SYM_W-1:0] sym);
    idx_t idx;
    if (int'(sym) >= ALPHABET) begin
      idx = IDX_W'(ALPHABET - 1);
    end else begin
      idx = IDX_W'(sym);
    end
    return idx;
  endfunction

  // Extend a run by one, saturating at the length limit
  function automatic len_t bump(input len_t len);
    len_t res;
    if (int'(len) >= MAX_LEN) begin
      res = LEN_W'(MAX_LEN);
    end else begin
      res = len + LEN_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lms_tables.sv */
// Per-symbol prefix and suffix maximum tables for rising and falling runs.
`default_nettype none

module lms_tables (
  input  wire                       clk,
  input  wire                       rst,
  input  wire lms_pkg::lms_req_t    req,
  output lms_pkg::len_t             best_next
);

  // rise_pm[k]: best rising run ending in any symbol <= k
  // fall_sm[k]: best falling run ending in any symbol >= k
  lms_pkg::len_t rise_pm      [lms_pkg::ALPHABET];
  lms_pkg::len_t fall_sm      [lms_pkg::ALPHABET];
  lms_pkg::len_t rise_pm_next [lms_pkg::ALPHABET];
  lms_pkg::len_t fall_sm_next [lms_pkg::ALPHABET];
  lms_pkg::len_t rise_len;
  lms_pkg::len_t fall_len;
  lms_pkg::len_t rise_top;
  lms_pkg::len_t fall_top;

  always_comb begin
    rise_len = lms_pkg::bump(rise_pm[req.idx]);
    fall_len = lms_pkg::bump(fall_sm[req.idx]);
    for (int k = 0; k < lms_pkg::ALPHABET; k++) begin
      if (k >= int'(req.idx) && rise_len > rise_pm[k]) begin
        rise_pm_next[k] = rise_len;
      end else begin
        rise_pm_next[k] = rise_pm[k];
      end
      if (k <= int'(req.idx) && fall_len > fall_sm[k]) begin
        fall_sm_next[k] = fall_len;
      end else begin
        fall_sm_next[k] = fall_sm[k];
      end
    end
    rise_top  = rise_pm_next[lms_pkg::ALPHABET-1];
    fall_top  = fall_sm_next[0];
    best_next = (rise_top > fall_top) ? rise_top : fall_top;
  end

  always_ff @(posedge clk) begin
    if (rst || (req.step && req.last)) begin
      for (int k = 0; k < lms_pkg::ALPHABET; k++) begin
        rise_pm[k] <= '0;
        fall_sm[k] <= '0;
      end
    end else if (req.step) begin
      for (int k = 0; k < lms_pkg::ALPHABET; k++) begin
        rise_pm[k] <= rise_pm_next[k];
        fall_sm[k] <= fall_sm_next[k];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/longest_monotone_subsequence.sv */
// Top level: stream wrapper around the monotone run tables.
// Flow: a symbol request is registered, then folded into the tables; a last
//   request also loads its result into the result register.
// Throughput: one request per cycle, but a last symbol stalls on a held result.
// Reset: rst (synchronous, active high) clears all tables and both valid flags.
`default_nettype none

module longest_monotone_subsequence (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         s_tvalid,
  output logic                        s_tready,
  input  wire  [lms_pkg::IN_W-1:0]    s_tdata,   // [4:0] symbol, rest zero
  input  wire                         s_tlast,   // last_symbol
  output logic                        m_tvalid,
  input  wire                         m_tready,
  output logic [lms_pkg::OUT_W-1:0]   m_tdata    // [10:0] best_length, rest zero
);

  // Input register: holds one symbol request until the tables take it
  logic                          in_valid;
  logic                          in_last;
  logic [lms_pkg::SYM_W-1:0]     in_sym;

  // Result register
  logic                          out_valid;
  lms_pkg::len_t                 out_len;

  lms_pkg::lms_req_t             req;
  lms_pkg::len_t                 best_next;
  logic                          step;

  // A plain symbol always folds in; a last symbol also needs room in the
  // result register (free, or draining this cycle).
  assign step     = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || step;

  assign req.step = step;
  assign req.last = in_last;
  assign req.idx  = lms_pkg::sym_to_idx(in_sym);

  lms_tables u_tables (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .best_next (best_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sym  <= s_tdata[lms_pkg::SYM_W-1:0];
      in_last <= s_tlast;
    end
  end

  // Load the string's best length on its last symbol; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_last) begin
      out_len <= best_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = lms_pkg::OUT_W'(out_len);

  // A finished string always reaches the result register
  a_last_loads: assert property (@(posedge clk) disable iff (rst)
    step && in_last |=> out_valid)
    else $error("last symbol did not load a result");

  // A stalled request in the input register is never overwritten
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_sym) && $stable(in_last))
    else $error("pending symbol request lost");

  // Any delivered length is at least one and within the limit
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len != '0) && (int'(out_len) <= lms_pkg::MAX_LEN))
    else $error("best length out of range");

  // A last symbol never folds in while an untaken result sits in the register
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    step && in_last && out_valid |-> m_tready)
    else $error("result overwritten before delivery");

endmodule

`default_nettype wire
